>>> src/bssc_pkg.sv
package bssc_pkg;

  // Geometry
  localparam int unsigned SECTOR_BYTES = 128;
  localparam int unsigned SECTOR_COUNT = 1024;
  localparam int unsigned IDX_W        = $clog2(SECTOR_BYTES);

  // Action codes of an input beat
  localparam logic [1:0] ACT_RESET = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // Byte positions shared by both commands
  localparam logic [7:0] POS_START   = 8'd2;
  localparam logic [7:0] POS_ID0     = 8'd2;
  localparam logic [7:0] POS_ID1     = 8'd3;
  localparam logic [7:0] POS_ADDR_HI = 8'd4;
  localparam logic [7:0] POS_ADDR_LO = 8'd5;

  // Read command positions
  localparam logic [7:0] POS_RD_ACK0    = 8'd6;
  localparam logic [7:0] POS_RD_ACK1    = 8'd7;
  localparam logic [7:0] POS_RD_ECHO_HI = 8'd8;
  localparam logic [7:0] POS_RD_ECHO_LO = 8'd9;
  localparam logic [7:0] POS_RD_DATA    = 8'd10;
  localparam logic [7:0] POS_RD_CSUM    = 8'(POS_RD_DATA + SECTOR_BYTES);
  localparam logic [7:0] POS_RD_END     = 8'(POS_RD_CSUM + 1);

  // Write command positions
  localparam logic [7:0] POS_WR_DATA = 8'd6;
  localparam logic [7:0] POS_WR_CSUM = 8'(POS_WR_DATA + SECTOR_BYTES);
  localparam logic [7:0] POS_WR_ACK0 = 8'(POS_WR_CSUM + 1);
  localparam logic [7:0] POS_WR_ACK1 = 8'(POS_WR_CSUM + 2);
  localparam logic [7:0] POS_WR_END  = 8'(POS_WR_CSUM + 3);

  // Reply bytes
  localparam logic [7:0] REPLY_ZERO        = 8'h00;
  localparam logic [7:0] REPLY_ID0         = 8'h5a;
  localparam logic [7:0] REPLY_ID1         = 8'h5d;
  localparam logic [7:0] REPLY_ACK0        = 8'h5c;
  localparam logic [7:0] REPLY_ACK1        = 8'h5d;
  localparam logic [7:0] REPLY_ABSENT      = 8'hff;
  localparam logic [7:0] REPLY_FILL        = 8'hff;
  localparam logic [7:0] STATUS_OK         = 8'h47;
  localparam logic [7:0] STATUS_BAD_CSUM   = 8'h4e;
  localparam logic [7:0] STATUS_BAD_SECTOR = 8'hff;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_in;
  } bssc_in_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       acknowledge;
    logic       directory_unread;
  } bssc_out_t;

  // Where the reply byte of a beat comes from
  typedef enum logic [2:0] {
    SRC_CONST,
    SRC_ENTRY,
    SRC_BUF,
    SRC_STORE,
    SRC_CSUM,
    SRC_STATUS
  } reply_src_e;

  typedef enum logic [1:0] {
    CSUM_KEEP,
    CSUM_SEED,
    CSUM_XOR
  } csum_op_e;

  // Decoded actions of one beat at the current byte position
  typedef struct packed {
    logic             has_result;
    logic             clear;
    logic             advance;
    logic             latch_high;
    logic             latch_low;
    logic             load;
    logic             buf_wr;
    logic [IDX_W-1:0] idx;
    reply_src_e       src;
    logic [7:0]       reply;
    logic             ack;
    csum_op_e         csum_op;
    logic             csum_from_data;
    logic             host_latch;
    logic             is_end;
  } bssc_dec_t;

endpackage

>>> src/bssc_decode.sv
module bssc_decode (
  input  bssc_pkg::bssc_in_t  item_i,
  input  logic [7:0]          pos_i,
  input  logic [7:0]          sector_high_i,
  input  logic [7:0]          sector_low_i,
  input  logic                present_i,
  output bssc_pkg::bssc_dec_t dec_o
);
  import bssc_pkg::*;

  logic [7:0] rd_off;
  logic [7:0] wr_off;
  bssc_dec_t  dec;

  assign rd_off = pos_i - POS_RD_DATA;
  assign wr_off = pos_i - POS_WR_DATA;
  assign dec_o  = dec;

  // Map action and byte position onto the reply and the state updates
  always_comb begin
    dec         = '0;
    dec.src     = SRC_CONST;
    dec.reply   = REPLY_ZERO;
    dec.csum_op = CSUM_KEEP;
    case (item_i.action)
      ACT_RESET: begin
        dec.clear = 1'b1;
      end
      ACT_READ: begin
        dec.has_result = 1'b1;
        if (!present_i) begin
          dec.reply = REPLY_ABSENT;
        end else begin
          dec.ack     = 1'b1;
          dec.advance = 1'b1;
          if (pos_i == POS_ID0) begin
            dec.reply = REPLY_ID0;
          end else if (pos_i == POS_ID1) begin
            dec.reply = REPLY_ID1;
          end else if (pos_i == POS_ADDR_HI) begin
            dec.latch_high = 1'b1;
          end else if (pos_i == POS_ADDR_LO) begin
            dec.latch_low = 1'b1;
          end else if (pos_i == POS_RD_ACK0) begin
            dec.reply = REPLY_ACK0;
          end else if (pos_i == POS_RD_ACK1) begin
            dec.reply = REPLY_ACK1;
          end else if (pos_i == POS_RD_ECHO_HI) begin
            dec.reply = sector_high_i;
          end else if (pos_i == POS_RD_ECHO_LO) begin
            dec.reply = sector_low_i;
          end else if (pos_i >= POS_RD_DATA && pos_i < POS_RD_CSUM) begin
            // first data byte marks the buffer as holding the whole sector (fill if the sector is bad)
            dec.src     = SRC_ENTRY;
            dec.idx     = rd_off[IDX_W-1:0];
            dec.load    = (pos_i == POS_RD_DATA);
            dec.csum_op = (pos_i == POS_RD_DATA) ? CSUM_SEED : CSUM_XOR;
          end else if (pos_i == POS_RD_CSUM) begin
            dec.src = SRC_CSUM;
          end else if (pos_i == POS_RD_END) begin
            dec.reply = STATUS_OK;
            dec.ack   = 1'b0;
          end else begin
            dec.ack     = 1'b0;
            dec.advance = 1'b0;
          end
        end
      end
      ACT_WRITE: begin
        dec.has_result = 1'b1;
        dec.ack        = 1'b1;
        dec.advance    = 1'b1;
        if (pos_i == POS_ID0) begin
          dec.reply = REPLY_ID0;
        end else if (pos_i == POS_ID1) begin
          dec.reply = REPLY_ID1;
        end else if (pos_i == POS_ADDR_HI) begin
          dec.latch_high = 1'b1;
        end else if (pos_i == POS_ADDR_LO) begin
          dec.latch_low = 1'b1;
        end else if (pos_i >= POS_WR_DATA && pos_i < POS_WR_CSUM) begin
          dec.buf_wr         = 1'b1;
          dec.idx            = wr_off[IDX_W-1:0];
          dec.csum_from_data = 1'b1;
          dec.csum_op        = (pos_i == POS_WR_DATA) ? CSUM_SEED : CSUM_XOR;
        end else if (pos_i == POS_WR_CSUM) begin
          dec.host_latch = 1'b1;
        end else if (pos_i == POS_WR_ACK0) begin
          dec.reply = REPLY_ACK0;
        end else if (pos_i == POS_WR_ACK1) begin
          dec.reply = REPLY_ACK1;
        end else if (pos_i == POS_WR_END) begin
          dec.src    = SRC_STATUS;
          dec.is_end = 1'b1;
          dec.ack    = 1'b0;
        end else begin
          dec.ack     = 1'b0;
          dec.advance = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> src/byte_serial_sector_card_unit.sv
// Emulated byte-serial memory card: each input beat is one exchanged byte of a
// sector read or sector write (or a transaction reset), and every read or
// write beat returns one reply beat. The block takes one byte per clock while
// neither the reply stage nor the copy holds input; a beat is decoded and the
// sector buffer and card store are read in the accept cycle, and the reply is
// formed from the registered read data in the reply stage and then registered
// in the output register. A write whose status byte commits the sector holds
// off input after that byte while the status resolves, while the buffer is
// copied into the card store through its single write port, and until the
// last write is done. The card store holds SECTOR_COUNT sectors of 128 bytes
// and is not cleared; only sectors that have been written may be read.
module byte_serial_sector_card_unit #(
  parameter int unsigned SECTOR_COUNT = bssc_pkg::SECTOR_COUNT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bssc_pkg::bssc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bssc_pkg::bssc_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);
  import bssc_pkg::*;

  localparam int unsigned STORE_DEPTH = SECTOR_COUNT * SECTOR_BYTES;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned SEC_W       = ADDR_W - IDX_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SECTOR_BYTES - 1);

  // Contents of buffer entries not written since the last bulk operation
  typedef enum logic [1:0] {
    BUF_ZERO,
    BUF_FF,
    BUF_STORE
  } buf_mode_e;

  typedef struct packed {
    logic       has_result;
    logic       clear;
    reply_src_e src;
    logic [7:0] reply;
    logic       ack;
    csum_op_e   csum_op;
    logic       csum_from_data;
    logic [7:0] data;
    logic [7:0] seed;
    logic       host_latch;
    logic       is_end;
    logic       good;
  } stage_t;

  // Configuration and front-end state
  logic                    card_present_q;
  logic [7:0]              pos_q;
  logic [7:0]              sec_hi_q;
  logic [7:0]              sec_lo_q;
  logic                    good_q;
  buf_mode_e               mode_q;
  logic [SEC_W-1:0]        load_sec_q;
  logic [SECTOR_BYTES-1:0] wvalid_q;

  // Memories and their registered read data
  logic [7:0] wbuf_mem  [SECTOR_BYTES];
  logic [7:0] store_mem [STORE_DEPTH];
  logic [7:0] wbuf_rd_q;
  logic [7:0] store_rd_q;

  // Reply stage, checksums and flag
  logic       s1_valid_q;
  stage_t     s1_q;
  logic [7:0] csum_q;
  logic [7:0] csum_d;
  logic [7:0] host_q;
  logic [7:0] host_d;
  logic       flag_q;
  logic       flag_d;
  logic       out_valid_q;
  bssc_out_t  out_q;

  // Sector copy engine
  logic             cp_rd_q;
  logic [IDX_W-1:0] cp_idx_q;
  logic             cp_wr_q;
  logic [IDX_W-1:0] cp_wr_idx_q;
  logic             cp_wbit_q;
  logic             cp_busy;
  logic [7:0]       cp_wdata;

  // Front-end decode signals
  bssc_dec_t        dec;
  logic             in_fire;
  logic [15:0]      cur_sec;
  logic             low_in_range;
  buf_mode_e        mode_eff;
  logic             wbit_eff;
  logic [SEC_W-1:0] load_sec_eff;
  reply_src_e       src_res;
  logic [7:0]       const_res;
  logic             wbuf_re;
  logic [IDX_W-1:0] wbuf_raddr;
  logic             store_re;
  logic [ADDR_W-1:0] store_raddr;

  // Reply stage signals
  logic       s1_adv;
  logic       s1_fire;
  logic [7:0] reply;
  logic [7:0] status;
  logic       status_ok;
  logic [7:0] csum_opnd;
  logic       commit;

  bssc_decode u_decode (
    .item_i       (in_data_i),
    .pos_i        (pos_q),
    .sector_high_i(sec_hi_q),
    .sector_low_i (sec_lo_q),
    .present_i    (card_present_q),
    .dec_o        (dec)
  );

  // Configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      card_present_q <= 1'b1;
    end else if (cfg_valid_i) begin
      card_present_q <= cfg_data_i;
    end
  end

  // Hold input while the reply stage is stalled, the status byte resolves or the copy runs
  assign cp_busy    = cp_rd_q || cp_wr_q;
  assign s1_adv     = !s1_q.has_result || !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_ready_o = !cp_busy && (!s1_valid_q || (s1_adv && !s1_q.is_end));
  assign in_fire    = in_valid_i && in_ready_o;

  // Resolve the buffer entry a read beat returns
  assign cur_sec      = {sec_hi_q, sec_lo_q};
  assign low_in_range = {sec_hi_q, in_data_i.data_in} < 16'(SECTOR_COUNT);
  assign mode_eff     = dec.load ? (good_q ? BUF_STORE : BUF_FF) : mode_q;
  assign wbit_eff     = dec.load ? 1'b0 : wvalid_q[dec.idx];
  assign load_sec_eff = dec.load ? cur_sec[SEC_W-1:0] : load_sec_q;

  always_comb begin
    src_res   = dec.src;
    const_res = dec.reply;
    if (dec.src == SRC_ENTRY) begin
      if (wbit_eff) begin
        src_res = SRC_BUF;
      end else if (mode_eff == BUF_STORE) begin
        src_res = SRC_STORE;
      end else begin
        src_res   = SRC_CONST;
        const_res = (mode_eff == BUF_FF) ? REPLY_FILL : REPLY_ZERO;
      end
    end
  end

  // Share the read ports between beats and the copy engine
  assign wbuf_re     = cp_rd_q || (in_fire && src_res == SRC_BUF);
  assign wbuf_raddr  = cp_rd_q ? cp_idx_q : dec.idx;
  assign store_re    = cp_rd_q || (in_fire && src_res == SRC_STORE);
  assign store_raddr = cp_rd_q ? {load_sec_q, cp_idx_q} : {load_sec_eff, dec.idx};

  // Front-end state: position, address, buffer bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= POS_START;
      sec_hi_q   <= '0;
      sec_lo_q   <= '0;
      good_q     <= 1'b0;
      mode_q     <= BUF_ZERO;
      load_sec_q <= '0;
      wvalid_q   <= '0;
    end else if (in_fire) begin
      if (dec.clear) begin
        pos_q    <= POS_START;
        sec_hi_q <= '0;
        sec_lo_q <= '0;
        mode_q   <= BUF_ZERO;
        wvalid_q <= '0;
      end else begin
        if (dec.advance) begin
          pos_q <= pos_q + 8'd1;
        end
        if (dec.latch_high) begin
          sec_hi_q <= in_data_i.data_in;
        end
        if (dec.latch_low) begin
          sec_lo_q <= in_data_i.data_in;
          good_q   <= low_in_range;
        end
        if (dec.load) begin
          mode_q     <= mode_eff;
          load_sec_q <= load_sec_eff;
          wvalid_q   <= '0;
        end else if (dec.buf_wr) begin
          wvalid_q[dec.idx] <= 1'b1;
        end
      end
    end
  end

  // Sector buffer memory
  always_ff @(posedge clk_i) begin
    if (in_fire && dec.buf_wr) begin
      wbuf_mem[dec.idx] <= in_data_i.data_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wbuf_re) begin
      wbuf_rd_q <= wbuf_mem[wbuf_raddr];
    end
  end

  // Card store memory
  always_ff @(posedge clk_i) begin
    if (cp_wr_q) begin
      store_mem[{cur_sec[SEC_W-1:0], cp_wr_idx_q}] <= cp_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_re) begin
      store_rd_q <= store_mem[store_raddr];
    end
  end

  // Reply stage: capture the decoded beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= dec.clear || dec.has_result;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.has_result     <= dec.has_result;
      s1_q.clear          <= dec.clear;
      s1_q.src            <= src_res;
      s1_q.reply          <= const_res;
      s1_q.ack            <= dec.ack;
      s1_q.csum_op        <= dec.csum_op;
      s1_q.csum_from_data <= dec.csum_from_data;
      s1_q.data           <= in_data_i.data_in;
      s1_q.seed           <= sec_hi_q ^ sec_lo_q;
      s1_q.host_latch     <= dec.host_latch;
      s1_q.is_end         <= dec.is_end;
      s1_q.good           <= good_q;
    end
  end

  // Form the reply and the checksum updates
  assign status_ok = s1_q.good && (host_q == csum_q);
  assign status    = !s1_q.good ? STATUS_BAD_SECTOR :
                     (host_q != csum_q) ? STATUS_BAD_CSUM : STATUS_OK;

  always_comb begin
    case (s1_q.src)
      SRC_BUF:    reply = wbuf_rd_q;
      SRC_STORE:  reply = store_rd_q;
      SRC_CSUM:   reply = csum_q;
      SRC_STATUS: reply = status;
      default:    reply = s1_q.reply;
    endcase
  end

  assign csum_opnd = s1_q.csum_from_data ? s1_q.data : reply;

  always_comb begin
    if (s1_q.clear) begin
      csum_d = '0;
    end else begin
      case (s1_q.csum_op)
        CSUM_SEED: csum_d = s1_q.seed ^ csum_opnd;
        CSUM_XOR:  csum_d = csum_q ^ csum_opnd;
        default:   csum_d = csum_q;
      endcase
    end
  end

  assign host_d = s1_q.clear ? 8'h00 : (s1_q.host_latch ? s1_q.data : host_q);
  assign flag_d = (s1_q.is_end && status_ok) ? 1'b0 : flag_q;
  assign commit = s1_fire && s1_q.is_end && status_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csum_q <= '0;
      host_q <= '0;
      flag_q <= 1'b1;
    end else if (s1_fire) begin
      csum_q <= csum_d;
      host_q <= host_d;
      flag_q <= flag_d;
    end
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_q.has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_q.has_result) begin
      out_q.reply_byte       <= reply;
      out_q.acknowledge      <= s1_q.ack;
      out_q.directory_unread <= flag_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Copy engine: read entry k, write it to the store in the following cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_rd_q  <= 1'b0;
      cp_idx_q <= '0;
      cp_wr_q  <= 1'b0;
    end else begin
      cp_wr_q <= cp_rd_q;
      if (commit) begin
        cp_rd_q  <= 1'b1;
        cp_idx_q <= '0;
      end else if (cp_rd_q) begin
        cp_idx_q <= cp_idx_q + 1'b1;
        if (cp_idx_q == IDX_LAST) begin
          cp_rd_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cp_rd_q) begin
      cp_wr_idx_q <= cp_idx_q;
      cp_wbit_q   <= wvalid_q[cp_idx_q];
    end
  end

  always_comb begin
    if (cp_wbit_q) begin
      cp_wdata = wbuf_rd_q;
    end else begin
      case (mode_q)
        BUF_STORE: cp_wdata = store_rd_q;
        BUF_FF:    cp_wdata = REPLY_FILL;
        default:   cp_wdata = REPLY_ZERO;
      endcase
    end
  end

endmodule

>>> src/bssc_checker.sv
module bssc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input bssc_pkg::bssc_out_t out_data_o
);
  import bssc_pkg::*;

  logic out_fire;
  logic in_fire;
  logic last_flag_q;

  assign out_fire = out_valid_o && out_ready_i;
  assign in_fire  = in_valid_i && in_ready_o;

  // Track the directory flag as last delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_flag_q <= 1'b1;
    end else if (out_fire) begin
      last_flag_q <= out_data_o.directory_unread;
    end
  end

  // A stalled reply beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("reply beat changed while stalled");

  // Once cleared the flag never comes back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !last_flag_q |-> !out_data_o.directory_unread)
    else $error("directory flag set again");

  // The flag drops only on a successful write status beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && last_flag_q && !out_data_o.directory_unread |->
      out_data_o.reply_byte == STATUS_OK && !out_data_o.acknowledge)
    else $error("directory flag cleared outside a committed write");

  // A reply appears only after an accepted input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_fire, 2))
    else $error("reply beat without an input beat");

endmodule

bind byte_serial_sector_card_unit bssc_checker u_bssc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

>>> tb/tb_byte_serial_sector_card_unit.sv
`timescale 1ns / 1ps

module tb_byte_serial_sector_card_unit;
  import bssc_pkg::*;

  localparam int unsigned NUM_SECTORS   = 1024;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam logic [1:0]  ACT_UNUSED    = 2'd3;

  logic clk;
  logic rst_n = 1'b0;

  logic      in_valid  = 1'b0;
  logic      in_ready_o;
  bssc_in_t  in_beat   = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  bssc_out_t out_data_o;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_bit   = 1'b0;

  byte_serial_sector_card_unit #(
    .SECTOR_COUNT(NUM_SECTORS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_beat),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_bit)
  );

  // Card state as the host side expects it
  logic [7:0] cur_pos    = POS_START;
  logic [7:0] sect_hi    = 8'h00;
  logic [7:0] sect_lo    = 8'h00;
  logic [7:0] run_sum    = 8'h00;
  logic [7:0] host_sum   = 8'h00;
  logic       sect_ok    = 1'b0;
  logic       dir_unread = 1'b1;
  logic       card_on    = 1'b1;
  logic [7:0] sect_buf [SECTOR_BYTES] = '{default: 8'h00};
  logic [7:0] card_mem [SECTOR_BYTES * NUM_SECTORS];

  bssc_in_t    host_bytes  [$];
  bssc_out_t   replies_due [$];
  bssc_out_t   due_reply;
  bssc_out_t   want;
  int unsigned beats_queued = 0;
  int unsigned beats_taken  = 0;
  int unsigned beats_counted = 0;
  int unsigned errors = 0;

  // Planning view: enough to know where each planned beat lands
  int          g_pos = POS_START;
  logic [7:0]  g_hi  = 8'h00;
  logic [7:0]  g_lo  = 8'h00;
  logic        g_on  = 1'b1;
  bit          known_written [NUM_SECTORS] = '{default: 1'b0};
  logic [15:0] written_list [$];

  int unsigned in_gap    = 0;
  bit          in_calm   = 1'b0;
  int unsigned out_stall = 0;
  bit          out_calm  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Work out the reply of one host byte and advance the card state
  function automatic bit card_reply(input bssc_in_t beat, output bssc_out_t res);
    logic [7:0]  d;
    logic [7:0]  rep;
    logic        ack;
    bit          moves;
    int unsigned sec;
    int          i;
    d     = beat.data_in;
    rep   = REPLY_ZERO;
    ack   = 1'b1;
    moves = 1'b1;
    res   = '0;
    if (beat.action == ACT_RESET) begin
      // Drop the transaction; the sector flag and the unread flag survive
      cur_pos  = POS_START;
      sect_hi  = 8'h00;
      sect_lo  = 8'h00;
      run_sum  = 8'h00;
      host_sum = 8'h00;
      for (i = 0; i < SECTOR_BYTES; i++) sect_buf[i] = 8'h00;
      return 1'b0;
    end
    if (beat.action == ACT_READ) begin
      if (!card_on) begin
        rep   = REPLY_ABSENT;
        ack   = 1'b0;
        moves = 1'b0;
      end else if (cur_pos == POS_ID0) begin
        rep = REPLY_ID0;
      end else if (cur_pos == POS_ID1) begin
        rep = REPLY_ID1;
      end else if (cur_pos == POS_ADDR_HI) begin
        sect_hi = d;
      end else if (cur_pos == POS_ADDR_LO) begin
        sect_lo = d;
        sect_ok = ({sect_hi, d} < NUM_SECTORS);
      end else if (cur_pos == POS_RD_ACK0) begin
        rep = REPLY_ACK0;
      end else if (cur_pos == POS_RD_ACK1) begin
        rep = REPLY_ACK1;
      end else if (cur_pos == POS_RD_ECHO_HI) begin
        rep = sect_hi;
      end else if (cur_pos == POS_RD_ECHO_LO) begin
        rep = sect_lo;
      end else if (cur_pos >= POS_RD_DATA && cur_pos < POS_RD_CSUM) begin
        // Load the sector on the first data byte; a bad sector reads as fill
        if (cur_pos == POS_RD_DATA) begin
          run_sum = sect_hi ^ sect_lo;
          sec     = {sect_hi, sect_lo};
          for (i = 0; i < SECTOR_BYTES; i++) begin
            sect_buf[i] = (sect_ok && sec < NUM_SECTORS) ?
                          card_mem[sec * SECTOR_BYTES + i] : REPLY_FILL;
          end
        end
        rep     = sect_buf[cur_pos - POS_RD_DATA];
        run_sum = run_sum ^ rep;
      end else if (cur_pos == POS_RD_CSUM) begin
        rep = run_sum;
      end else if (cur_pos == POS_RD_END) begin
        rep = STATUS_OK;
        ack = 1'b0;
      end else begin
        ack   = 1'b0;
        moves = 1'b0;
      end
    end else if (beat.action == ACT_WRITE) begin
      // Writes go ahead whether or not the card is present
      if (cur_pos == POS_ID0) begin
        rep = REPLY_ID0;
      end else if (cur_pos == POS_ID1) begin
        rep = REPLY_ID1;
      end else if (cur_pos == POS_ADDR_HI) begin
        sect_hi = d;
      end else if (cur_pos == POS_ADDR_LO) begin
        sect_lo = d;
        sect_ok = ({sect_hi, d} < NUM_SECTORS);
      end else if (cur_pos >= POS_WR_DATA && cur_pos < POS_WR_CSUM) begin
        if (cur_pos == POS_WR_DATA) run_sum = sect_hi ^ sect_lo;
        sect_buf[cur_pos - POS_WR_DATA] = d;
        run_sum = run_sum ^ d;
      end else if (cur_pos == POS_WR_CSUM) begin
        host_sum = d;
      end else if (cur_pos == POS_WR_ACK0) begin
        rep = REPLY_ACK0;
      end else if (cur_pos == POS_WR_ACK1) begin
        rep = REPLY_ACK1;
      end else if (cur_pos == POS_WR_END) begin
        sec = {sect_hi, sect_lo};
        if (!sect_ok || sec >= NUM_SECTORS) begin
          rep = STATUS_BAD_SECTOR;
        end else if (host_sum != run_sum) begin
          rep = STATUS_BAD_CSUM;
        end else begin
          for (i = 0; i < SECTOR_BYTES; i++) card_mem[sec * SECTOR_BYTES + i] = sect_buf[i];
          rep        = STATUS_OK;
          dir_unread = 1'b0;
        end
        ack = 1'b0;
      end else begin
        ack   = 1'b0;
        moves = 1'b0;
      end
    end else begin
      return 1'b0;
    end
    if (moves) cur_pos = cur_pos + 8'd1;
    res.reply_byte       = rep;
    res.acknowledge      = ack;
    res.directory_unread = dir_unread;
    return 1'b1;
  endfunction

  function automatic int unsigned idle_len(input bit calm);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Queue one host byte and track where it leaves the card
  task automatic push_beat(input logic [1:0] act, input logic [7:0] d);
    bssc_in_t    beat;
    logic [1:0]  a;
    int unsigned sec;
    a   = act;
    sec = {g_hi, g_lo};
    // Never load an in-range sector that has not been written: reset instead
    if (a == ACT_READ && g_on && g_pos == POS_RD_DATA && sec < NUM_SECTORS &&
        !known_written[sec]) a = ACT_RESET;
    beat.action  = a;
    beat.data_in = d;
    host_bytes.push_back(beat);
    beats_queued++;
    if (a != ACT_UNUSED) beats_counted++;
    if (a == ACT_RESET) begin
      g_pos = POS_START;
      g_hi  = 8'h00;
      g_lo  = 8'h00;
    end else if (a == ACT_READ && g_on) begin
      if (g_pos == POS_ADDR_HI) g_hi = d;
      if (g_pos == POS_ADDR_LO) g_lo = d;
      if (g_pos >= POS_START && g_pos <= POS_RD_END) g_pos++;
    end else if (a == ACT_WRITE) begin
      if (g_pos == POS_ADDR_HI) g_hi = d;
      if (g_pos == POS_ADDR_LO) g_lo = d;
      if (g_pos >= POS_START && g_pos <= POS_WR_END) g_pos++;
    end
  endtask

  function automatic logic [15:0] pick_good_sector();
    int unsigned r;
    r = $urandom_range(9, 0);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'(NUM_SECTORS - 1);
    if (r < 6) return 16'($urandom_range(7, 0));
    return 16'($urandom_range(NUM_SECTORS - 1, 0));
  endfunction

  function automatic logic [15:0] pick_bad_sector();
    int unsigned r;
    r = $urandom_range(2, 0);
    if (r == 0) return 16'hffff;
    if (r == 1) return 16'(NUM_SECTORS);
    return {8'($urandom_range(255, 4)), 8'($urandom)};
  endfunction

  // Full sector write, with the checksum right unless spoilt
  task automatic plan_write(input logic [15:0] addr, input bit spoil);
    logic [7:0]  sum;
    logic [7:0]  d;
    int unsigned fill;
    int          i;
    fill = $urandom_range(9, 0);
    sum  = addr[15:8] ^ addr[7:0];
    push_beat(ACT_RESET, 8'($urandom));
    push_beat(ACT_WRITE, 8'($urandom));
    push_beat(ACT_WRITE, 8'($urandom));
    push_beat(ACT_WRITE, addr[15:8]);
    push_beat(ACT_WRITE, addr[7:0]);
    for (i = 0; i < SECTOR_BYTES; i++) begin
      case (fill)
        0:       d = 8'h00;
        1:       d = 8'hff;
        2:       d = i[0] ? 8'haa : 8'h55;
        default: d = 8'($urandom);
      endcase
      sum = sum ^ d;
      push_beat(ACT_WRITE, d);
    end
    push_beat(ACT_WRITE, spoil ? (sum ^ 8'($urandom_range(255, 1))) : sum);
    repeat (3) push_beat(ACT_WRITE, 8'($urandom));
    // Bytes past the end of the sequence
    repeat ($urandom_range(3, 0)) begin
      push_beat($urandom_range(1, 0) ? ACT_READ : ACT_WRITE, 8'($urandom));
    end
    if (!spoil && addr < NUM_SECTORS && !known_written[addr]) begin
      known_written[addr] = 1'b1;
      written_list.push_back(addr);
    end
  endtask

  // Sector read of a written or out-of-range sector; short while the card is out
  task automatic plan_read();
    logic [15:0] addr;
    logic [7:0]  p;
    int          n;
    int          k;
    if (written_list.size() > 0 && $urandom_range(9, 0) < 8) begin
      addr = written_list[$urandom_range(written_list.size() - 1, 0)];
    end else begin
      addr = pick_bad_sector();
    end
    n = g_on ? int'(POS_RD_END - POS_START) + 1 : $urandom_range(12, 3);
    push_beat(ACT_RESET, 8'($urandom));
    for (k = 0; k < n; k++) begin
      p = POS_START + 8'(k);
      push_beat(ACT_READ, (p == POS_ADDR_HI) ? addr[15:8] :
                          (p == POS_ADDR_LO) ? addr[7:0] : 8'($urandom));
    end
    repeat ($urandom_range(3, 0)) begin
      push_beat($urandom_range(1, 0) ? ACT_READ : ACT_WRITE, 8'($urandom));
    end
  endtask

  // Short mixed run of any action, addresses sometimes pointing at real sectors
  task automatic plan_noise();
    logic [15:0] addr;
    logic [7:0]  d;
    logic [1:0]  a;
    int unsigned r;
    int          n;
    int          k;
    if (written_list.size() > 0 && $urandom_range(1, 0)) begin
      addr = written_list[$urandom_range(written_list.size() - 1, 0)];
    end else begin
      addr = 16'($urandom);
    end
    if ($urandom_range(1, 0)) push_beat(ACT_RESET, 8'($urandom));
    n = $urandom_range(30, 4);
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99, 0);
      a = (r < 45) ? ACT_READ : (r < 85) ? ACT_WRITE : (r < 92) ? ACT_RESET : ACT_UNUSED;
      d = (g_pos == POS_ADDR_HI) ? addr[15:8] :
          (g_pos == POS_ADDR_LO) ? addr[7:0] : 8'($urandom);
      push_beat(a, d);
    end
  endtask

  task automatic plan_random(input int unsigned count);
    int unsigned start;
    int unsigned r;
    start = beats_counted;
    while (beats_counted - start < count) begin
      r = $urandom_range(99, 0);
      if (r < 35) plan_write(pick_good_sector(), 1'b0);
      else if (r < 40) plan_write(pick_good_sector(), 1'b1);
      else if (r < 45) plan_write(pick_bad_sector(), 1'($urandom_range(1, 0)));
      else if (r < 72) plan_read();
      else plan_noise();
    end
  endtask

  // Wait for every queued beat and its reply, then let a sector commit finish
  task automatic drain();
    while (beats_taken != beats_queued || replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_card_present(input logic on);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_bit   <= on;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    card_on = on;
    g_on    = on;
  endtask

  // Offer host bytes; predict the reply of each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        if (card_reply(in_beat, due_reply)) replies_due.push_back(due_reply);
        beats_taken++;
        in_gap = idle_len(in_calm);
        if ($urandom_range(199, 0) == 0) in_calm = !in_calm;
      end
      if (!in_valid || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (host_bytes.size() > 0) begin
          in_beat  <= host_bytes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Take reply beats with random back-pressure and check each against the oldest due
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (replies_due.size() == 0) begin
          if (errors < 25) begin
            $display("%0t: reply with none due: byte %02h ack %0b unread %0b", $time,
                     out_data_o.reply_byte, out_data_o.acknowledge,
                     out_data_o.directory_unread);
          end
          errors++;
        end else begin
          want = replies_due.pop_front();
          if (out_data_o.reply_byte !== want.reply_byte ||
              out_data_o.acknowledge !== want.acknowledge ||
              out_data_o.directory_unread !== want.directory_unread) begin
            if (errors < 25) begin
              $display("%0t: reply mismatch: expected byte %02h ack %0b unread %0b, got %02h %0b %0b",
                       $time, want.reply_byte, want.acknowledge, want.directory_unread,
                       out_data_o.reply_byte, out_data_o.acknowledge,
                       out_data_o.directory_unread);
            end
            errors++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall = idle_len(out_calm);
        if ($urandom_range(199, 0) == 0) out_calm = !out_calm;
      end
    end
  end

  initial begin
    // Card present after reset: IDs, a bad-sector read into the data, ignored code
    push_beat(ACT_UNUSED, 8'hff);
    push_beat(ACT_READ, 8'h00);
    push_beat(ACT_READ, 8'hff);
    push_beat(ACT_READ, 8'hff);
    push_beat(ACT_READ, 8'hff);
    push_beat(ACT_READ, 8'h00);
    push_beat(ACT_READ, 8'h00);
    push_beat(ACT_READ, 8'h00);
    push_beat(ACT_READ, 8'hff);
    push_beat(ACT_READ, 8'h00);
    // Write header to the last sector, then a read header to the first bad one
    push_beat(ACT_RESET, 8'haa);
    push_beat(ACT_WRITE, 8'h00);
    push_beat(ACT_WRITE, 8'hff);
    push_beat(ACT_WRITE, 8'h03);
    push_beat(ACT_WRITE, 8'hff);
    push_beat(ACT_WRITE, 8'h00);
    push_beat(ACT_WRITE, 8'hff);
    push_beat(ACT_RESET, 8'h55);
    push_beat(ACT_READ, 8'h00);
    push_beat(ACT_READ, 8'h00);
    push_beat(ACT_READ, 8'h04);
    push_beat(ACT_READ, 8'h00);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    drain();

    // Card out: reads answer absent and hold, writes still advance
    set_card_present(1'b0);
    push_beat(ACT_RESET, 8'h00);
    push_beat(ACT_READ, 8'h00);
    push_beat(ACT_READ, 8'hff);
    push_beat(ACT_WRITE, 8'h12);
    push_beat(ACT_WRITE, 8'hed);
    push_beat(ACT_READ, 8'h00);
    push_beat(ACT_UNUSED, 8'h00);
    drain();

    set_card_present(1'b1);
    plan_random(950);
    drain();

    set_card_present(1'b0);
    plan_random(220);
    drain();

    set_card_present(1'b1);
    plan_random(280);
    drain();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop in case the card hangs
  initial begin
    #6000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
src/bssc_pkg.sv
src/bssc_decode.sv
src/byte_serial_sector_card_unit.sv
src/bssc_checker.sv
tb/tb_byte_serial_sector_card_unit.sv
